@@ hw/rtl/message_id_remap_table_top_defines.svh @@
// Assertion macros for the message-ID remap table checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef MESSAGE_ID_REMAP_TABLE_TOP_DEFINES_SVH
`define MESSAGE_ID_REMAP_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define MIRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mirt assertion failed");

// next-cycle implication
`define MIRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mirt assertion failed");

`endif

@@ hw/rtl/mirt_pkg.sv @@
// Shared types and constants for the message-ID remap table.
// Used by mirt_cell, the top level and the checker.
package mirt_pkg;

    localparam int TABLE_DEPTH = 64;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_FWD    = 2'd2,
        FUNC_REV    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] proc_id;
        logic [15:0] msg_id;
        logic [15:0] new_target_id;
    } req_item_t;

    typedef struct packed {
        logic [15:0] out_msg_id;
        logic        send;
        status_t     status;
    } rsp_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] proc_id;
        logic [15:0] source;
        logic [15:0] target;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic clear;
        logic shift;
        logic load;
        logic set_tgt;
    } cell_ctrl_t;

    typedef struct packed {
        logic ge;
        logic eq;
        logic rmatch;
    } cell_flag_t;

    // inclusive prefix OR, log-depth
    function automatic logic [TABLE_DEPTH-1:0] prefix_or(input logic [TABLE_DEPTH-1:0] v);
        logic [TABLE_DEPTH-1:0] p;
        p = v;
        for (int s = 1; s < TABLE_DEPTH; s = s * 2)
        begin
            p = p | (p << s);
        end
        return p;
    endfunction

endpackage

@@ hw/rtl/mirt_cell.sv @@
// One table slot: holds an entry, compares it with the broadcast key,
// and shifts in its left neighbor's entry on insert. Depends on mirt_pkg.
module mirt_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mirt_pkg::req_item_t    key,
    input  mirt_pkg::req_item_t    item,
    input  mirt_pkg::entry_t       left,
    input  mirt_pkg::cell_ctrl_t   ctrl,
    output mirt_pkg::entry_t       entry,
    output mirt_pkg::cell_flag_t   flag
);
    import mirt_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] proc_reg, proc_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] tgt_reg, tgt_next;
    cell_flag_t  flag_reg, flag_next;
    logic        proc_gt;
    logic        proc_eq;

    always_comb
    begin
        proc_gt          = proc_reg > key.proc_id;
        proc_eq          = proc_reg == key.proc_id;
        flag_next.ge     = !valid_reg || proc_gt || (proc_eq && src_reg >= key.msg_id);
        flag_next.eq     = valid_reg && proc_eq && src_reg == key.msg_id;
        flag_next.rmatch = valid_reg && proc_eq && tgt_reg == key.msg_id;
    end

    always_comb
    begin
        valid_next = valid_reg;
        proc_next  = proc_reg;
        src_next   = src_reg;
        tgt_next   = tgt_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_next = 1'b1;
            proc_next  = item.proc_id;
            src_next   = item.msg_id;
            tgt_next   = item.new_target_id;
        end
        else if (ctrl.shift)
        begin
            valid_next = left.valid;
            proc_next  = left.proc_id;
            src_next   = left.source;
            tgt_next   = left.target;
        end
        else if (ctrl.set_tgt)
        begin
            tgt_next = item.new_target_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg <= proc_next;
        src_reg  <= src_next;
        tgt_reg  <= tgt_next;
        if (ctrl.capture)
        begin
            flag_reg <= flag_next;
        end
    end

    assign entry = '{valid: valid_reg, proc_id: proc_reg, source: src_reg, target: tgt_reg};
    assign flag  = flag_reg;

endmodule

@@ hw/rtl/message_id_remap_table_top.sv @@
// Message-ID remap table: a row of TABLE_DEPTH cells kept sorted by (processor, source ID).
// For every item, at the accepting edge each cell registers its compare of the key against
// its own entry; in the next cycle the control decides, the cells clear, overwrite or shift
// one place right, and the result is registered. A new request is taken once that
// result is taken or the output register is free. Depends on mirt_pkg and mirt_cell.
module message_id_remap_table_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mirt_pkg::req_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mirt_pkg::rsp_item_t  rsp,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata
);
    import mirt_pkg::*;

    state_t    state_reg, state_next;
    req_item_t item_reg;
    rsp_item_t rsp_reg, rsp_next;
    logic      rsp_valid_reg, rsp_valid_next;
    logic      default_send_reg;
    logic      capture;

    entry_t     cell_entry [TABLE_DEPTH];
    cell_flag_t cell_flag  [TABLE_DEPTH];
    cell_ctrl_t cell_ctrl  [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] ge_vec, ge_prev, eq_vec, rm_vec, pos_oh, rfirst;
    logic [15:0] hit_tgt, rev_src;
    logic        hit, rfound, zero_src, full, do_set, do_ins, exec;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t left_entry;
            if (gi == 0)
            begin : g_head
                assign left_entry = '0;
            end
            else
            begin : g_body
                assign left_entry = cell_entry[gi-1];
            end
            mirt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .key   (req),
                .item  (item_reg),
                .left  (left_entry),
                .ctrl  (cell_ctrl[gi]),
                .entry (cell_entry[gi]),
                .flag  (cell_flag[gi])
            );
        end
    endgenerate

    assign req_stall = (state_reg == S_EXEC) || (rsp_valid_reg && rsp_stall);
    assign capture   = req_valid && !req_stall;
    assign exec      = state_reg == S_EXEC;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            ge_vec[i] = cell_flag[i].ge;
            eq_vec[i] = cell_flag[i].eq;
            rm_vec[i] = cell_flag[i].rmatch;
        end
        // ge is monotone across the sorted row: first set bit is the insert slot
        ge_prev  = ge_vec << 1;
        pos_oh   = ge_vec & ~ge_prev;
        rfirst   = rm_vec & ~(prefix_or(rm_vec) << 1);
        hit      = |eq_vec;
        rfound   = |rm_vec;
        full     = cell_entry[TABLE_DEPTH-1].valid;
        zero_src = item_reg.msg_id == 16'h0000;
        hit_tgt  = '0;
        rev_src  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_tgt = hit_tgt | (eq_vec[i] ? cell_entry[i].target : 16'h0000);
            rev_src = rev_src | (rfirst[i] ? cell_entry[i].source : 16'h0000);
        end
        do_set = exec && item_reg.func == FUNC_INSERT && !zero_src && hit;
        do_ins = exec && item_reg.func == FUNC_INSERT && !zero_src && !hit && !full;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cell_ctrl[i].capture = capture;
            cell_ctrl[i].clear   = exec && item_reg.func == FUNC_CLEAR;
            cell_ctrl[i].load    = do_ins && pos_oh[i];
            cell_ctrl[i].shift   = do_ins && ge_prev[i];
            cell_ctrl[i].set_tgt = do_set && eq_vec[i];
        end
    end

    always_comb
    begin
        rsp_next = '{out_msg_id: 16'h0000, send: 1'b0, status: ST_OK};
        case (item_reg.func)
            FUNC_CLEAR:
            begin
                rsp_next.status = ST_OK;
            end
            FUNC_INSERT:
            begin
                if (zero_src)
                begin
                    rsp_next.status = ST_ZERO;
                end
                else if (!hit && full)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            FUNC_FWD:
            begin
                if (hit)
                begin
                    rsp_next.out_msg_id = hit_tgt;
                end
                else
                begin
                    rsp_next.status     = ST_MISS;
                    rsp_next.out_msg_id = default_send_reg ? item_reg.msg_id : 16'h0000;
                end
                rsp_next.send = rsp_next.out_msg_id != 16'h0000;
            end
            FUNC_REV:
            begin
                rsp_next.send       = 1'b1;
                rsp_next.status     = rfound ? ST_OK : ST_MISS;
                rsp_next.out_msg_id = rfound ? rev_src : item_reg.msg_id;
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next     = S_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rsp_valid_reg    <= 1'b0;
            default_send_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                default_send_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            item_reg <= req;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hw/rtl/mirt_checker.sv @@
// Port-level checker for message_id_remap_table_top, bound to the top level.
// Depends on mirt_pkg and message_id_remap_table_top_defines.svh.
`include "message_id_remap_table_top_defines.svh"

module mirt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_stall,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input mirt_pkg::rsp_item_t  rsp
);
    import mirt_pkg::*;

    // held result stays put
    `MIRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    // one transfer in flight: stall right after a request transfer
    `MIRT_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall)
    // result valid once the execute state after a request transfer is done
    `MIRT_ASSERT_NOW(a_latency, req_valid && !req_stall, ##2 rsp_valid)
    // rejected or full inserts never forward
    `MIRT_ASSERT_NOW(a_reject, rsp_valid && (rsp.status == ST_ZERO || rsp.status == ST_FULL),
        !rsp.send && rsp.out_msg_id == 16'h0000)

endmodule

bind message_id_remap_table_top mirt_checker u_mirt_checker (.*);
